// File: rtl/core/bpcs_pkg.sv
// ----------------------------------------------------------------------------
// Bit-plane compressed size: shared definitions
// Widths, code lengths and the types passed between the cost logic and the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

package bpcs_pkg;

   localparam int unsigned LineWords      = 8;
   localparam int unsigned DeltaCount     = LineWords - 1;
   localparam int unsigned WordWidth      = 32;
   localparam int unsigned DeltaWidth     = WordWidth + 1;
   localparam int unsigned PlaneCount     = DeltaWidth;
   localparam int unsigned GroupSize      = 7;
   localparam int unsigned GroupCount     = (PlaneCount + GroupSize - 1) / GroupSize;
   localparam int unsigned CostWidth      = 4;
   localparam int unsigned PartialWidth   = 6;
   localparam int unsigned BaseBitsWidth  = 6;
   localparam int unsigned PlaneBitsWidth = 9;
   localparam int unsigned TotalBitsWidth = 9;

   localparam logic [DeltaCount-1:0] PlaneAllOnes = 7'h7f;

   // Code lengths of the plane symbols.
   localparam logic [CostWidth-1:0] CostRunOne     = 4'd3;
   localparam logic [CostWidth-1:0] CostRunLong    = 4'd7;
   localparam logic [CostWidth-1:0] CostPlaneShort = 4'd5;
   localparam logic [CostWidth-1:0] CostPlaneLong  = 4'd8;

   // Code lengths of the base word.
   localparam logic [BaseBitsWidth-1:0] BaseZero   = 6'd3;
   localparam logic [BaseBitsWidth-1:0] BaseNibble = 6'd7;
   localparam logic [BaseBitsWidth-1:0] BaseByte   = 6'd11;
   localparam logic [BaseBitsWidth-1:0] BaseHalf   = 6'd19;
   localparam logic [BaseBitsWidth-1:0] BaseFull   = 6'd33;

   typedef logic [WordWidth-1:0]    word_type;
   typedef word_type [LineWords-1:0] line_type;

   typedef struct packed {
      logic [BaseBitsWidth-1:0]                  base_bits;
      logic [GroupCount-1:0][PartialWidth-1:0]   partial;
   } cost_type;

endpackage

`default_nettype wire

// File: rtl/core/bpcs_cost.sv
// ----------------------------------------------------------------------------
// Bit-plane compressed size: cost logic
// Forms the deltas and XOR planes of one line, prices every plane on its
// own and adds the prices in small groups; also prices the base word.
// ----------------------------------------------------------------------------
`default_nettype none

module bpcs_cost (
   input  var bpcs_pkg::line_type line,
   output var bpcs_pkg::cost_type cost
);
   import bpcs_pkg::*;

   logic [DeltaWidth-1:0]  delta      [DeltaCount];
   logic [DeltaCount-1:0]  plane      [PlaneCount];
   logic [DeltaCount-1:0]  xor_plane  [PlaneCount];
   logic [PlaneCount-1:0]  nonzero;
   logic [PlaneCount+1:0]  nonzero_ext;
   logic [CostWidth-1:0]   plane_cost [PlaneCount];
   word_type               base_word;
   logic [GroupCount-1:0][PartialWidth-1:0] partial;
   logic [BaseBitsWidth-1:0]                base_bits;

   always_comb begin
      for (int r = 0; r < DeltaCount; r++) begin
         delta[r] = {line[r+1][WordWidth-1], line[r+1]} - {line[r][WordWidth-1], line[r]};
      end
   end

   // Plane c holds bit c of every delta.
   always_comb begin
      for (int c = 0; c < PlaneCount; c++) begin
         for (int r = 0; r < DeltaCount; r++) begin
            plane[c][r] = delta[r][c];
         end
      end
   end

   always_comb begin
      xor_plane[PlaneCount-1] = plane[PlaneCount-1];
      for (int c = 0; c < PlaneCount - 1; c++) begin
         xor_plane[c] = plane[c] ^ plane[c+1];
      end
      for (int c = 0; c < PlaneCount; c++) begin
         nonzero[c] = |xor_plane[c];
      end
   end

   // Both ends are padded as nonzero so that a zero run is closed at plane 0
   // and opened at the top plane.
   assign nonzero_ext = {1'b1, nonzero, 1'b1};

   // A zero run is charged once, at its lowest plane; it is a run of one when
   // that plane is also its highest.
   always_comb begin
      for (int c = 0; c < PlaneCount; c++) begin
         if (nonzero[c]) begin
            if ((plane[c] == '0) || (xor_plane[c] == PlaneAllOnes)) begin
               plane_cost[c] = CostPlaneShort;
            end else begin
               plane_cost[c] = CostPlaneLong;
            end
         end else if (nonzero_ext[c]) begin
            plane_cost[c] = nonzero_ext[c+2] ? CostRunOne : CostRunLong;
         end else begin
            plane_cost[c] = '0;
         end
      end
   end

   always_comb begin
      for (int g = 0; g < GroupCount; g++) begin
         partial[g] = '0;
         for (int k = 0; k < GroupSize; k++) begin
            if (g * GroupSize + k < PlaneCount) begin
               partial[g] = partial[g]
                  + {{(PartialWidth-CostWidth){1'b0}}, plane_cost[g*GroupSize+k]};
            end
         end
      end
   end

   assign base_word = line[0];

   always_comb begin
      if (base_word == '0) begin
         base_bits = BaseZero;
      end else if ((&base_word[WordWidth-1:3]) || !(|base_word[WordWidth-1:3])) begin
         base_bits = BaseNibble;
      end else if ((&base_word[WordWidth-1:7]) || !(|base_word[WordWidth-1:7])) begin
         base_bits = BaseByte;
      end else if ((&base_word[WordWidth-1:15]) || !(|base_word[WordWidth-1:15])) begin
         base_bits = BaseHalf;
      end else begin
         base_bits = BaseFull;
      end
   end

   assign cost = '{base_bits: base_bits, partial: partial};

endmodule

`default_nettype wire

// File: rtl/core/bit_plane_compressed_size_top.sv
// ----------------------------------------------------------------------------
// Bit-plane compressed size of one 32-byte line
// Usage:
//   The req_ channel carries one line as eight 32-bit words per item; the
//   rsp_ channel returns one item per line with the base code length, the
//   length of the 33 coded delta planes and their sum, all in bits.
//   Both channels use valid/ready; an item moves when both are high.
//   The block is a three-register pipeline: input register, plane-cost
//   register (per-plane prices summed in groups of seven) and result
//   register. A taken item passes through the plane-cost register and then
//   the result register, and a new item is taken in every cycle while the
//   receiver keeps up, so the sustained rate is one line per clock.
//   When rsp_ready is low, the result holds and the stages behind it keep
//   filling until each holds an item; req_ready then falls.
//   Reset clears all valid flags; the pipeline is empty afterwards and no
//   result is presented until a new item arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module bit_plane_compressed_size_top (
   input  var logic                                  clock,
   input  var logic                                  reset,
   input  var logic                                  req_valid,
   output var logic                                  req_ready,
   input  var logic [bpcs_pkg::WordWidth-1:0]        req_word0,
   input  var logic [bpcs_pkg::WordWidth-1:0]        req_word1,
   input  var logic [bpcs_pkg::WordWidth-1:0]        req_word2,
   input  var logic [bpcs_pkg::WordWidth-1:0]        req_word3,
   input  var logic [bpcs_pkg::WordWidth-1:0]        req_word4,
   input  var logic [bpcs_pkg::WordWidth-1:0]        req_word5,
   input  var logic [bpcs_pkg::WordWidth-1:0]        req_word6,
   input  var logic [bpcs_pkg::WordWidth-1:0]        req_word7,
   output var logic                                  rsp_valid,
   input  var logic                                  rsp_ready,
   output var logic [bpcs_pkg::BaseBitsWidth-1:0]    rsp_base_bits,
   output var logic [bpcs_pkg::PlaneBitsWidth-1:0]   rsp_plane_bits,
   output var logic [bpcs_pkg::TotalBitsWidth-1:0]   rsp_total_bits
);
   import bpcs_pkg::*;

   logic                       s1_valid_ff;
   line_type                   s1_line_ff;
   logic                       s2_valid_ff;
   cost_type                   s2_cost_ff;
   cost_type                   cost_in;
   logic                       rsp_valid_ff;
   logic [BaseBitsWidth-1:0]   rsp_base_ff;
   logic [PlaneBitsWidth-1:0]  rsp_plane_ff;
   logic [TotalBitsWidth-1:0]  rsp_total_ff;
   logic [PlaneBitsWidth-1:0]  plane_in;
   logic [TotalBitsWidth-1:0]  total_in;
   logic                       s3_load;
   logic                       s2_load;
   logic                       s1_load;

   // Each stage loads when it is empty or its item moves on in this cycle.
   assign s3_load   = !rsp_valid_ff || rsp_ready;
   assign s2_load   = !s2_valid_ff || s3_load;
   assign s1_load   = !s1_valid_ff || s2_load;
   assign req_ready = s1_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_load) begin
         s1_valid_ff <= req_valid;
      end
      if (s1_load && req_valid) begin
         s1_line_ff <= {req_word7, req_word6, req_word5, req_word4,
                        req_word3, req_word2, req_word1, req_word0};
      end
   end

   bpcs_cost u_cost (
      .line (s1_line_ff),
      .cost (cost_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_load) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s2_load && s1_valid_ff) begin
         s2_cost_ff <= cost_in;
      end
   end

   always_comb begin
      plane_in = '0;
      for (int g = 0; g < GroupCount; g++) begin
         plane_in = plane_in
            + {{(PlaneBitsWidth-PartialWidth){1'b0}}, s2_cost_ff.partial[g]};
      end
      total_in = plane_in
         + {{(TotalBitsWidth-BaseBitsWidth){1'b0}}, s2_cost_ff.base_bits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s3_load) begin
         rsp_valid_ff <= s2_valid_ff;
      end
      if (s3_load && s2_valid_ff) begin
         rsp_base_ff  <= s2_cost_ff.base_bits;
         rsp_plane_ff <= plane_in;
         rsp_total_ff <= total_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_base_bits  = rsp_base_ff;
   assign rsp_plane_bits = rsp_plane_ff;
   assign rsp_total_bits = rsp_total_ff;

`ifndef NO_ASSERTIONS
   a_rsp_from_s2 : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s2_valid_ff))
      else $error("result became valid without an item in the cost stage");

   a_total_sum : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_total_ff
         == rsp_plane_ff + {{(TotalBitsWidth-BaseBitsWidth){1'b0}}, rsp_base_ff}))
      else $error("total length is not base plus planes");

   a_base_code : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_base_ff == BaseZero || rsp_base_ff == BaseNibble
         || rsp_base_ff == BaseByte || rsp_base_ff == BaseHalf
         || rsp_base_ff == BaseFull))
      else $error("base length is not a legal code length");

   a_plane_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_plane_ff >= 9'd7 && rsp_plane_ff <= 9'd264))
      else $error("plane length out of range");

   a_stall_full : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && s2_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("input stalled while the pipeline has room");
`endif

endmodule

`default_nettype wire

// File: dv/tb_bit_plane_compressed_size_top.sv
// ----------------------------------------------------------------------------
// Testbench for the bit-plane compressed size block
// Feeds 32-byte lines through the request channel, predicts the base, plane
// and total code lengths of each line, and checks every result in order.
// Both channels idle at random, and the result side is held off once for a
// long stretch so that the pipeline fills and stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bit_plane_compressed_size_top;

   import bpcs_pkg::*;

   typedef struct packed {
      logic [BaseBitsWidth-1:0]  base_bits;
      logic [PlaneBitsWidth-1:0] plane_bits;
      logic [TotalBitsWidth-1:0] total_bits;
   } size_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [WordWidth-1:0]      req_word0 = '0;
   logic [WordWidth-1:0]      req_word1 = '0;
   logic [WordWidth-1:0]      req_word2 = '0;
   logic [WordWidth-1:0]      req_word3 = '0;
   logic [WordWidth-1:0]      req_word4 = '0;
   logic [WordWidth-1:0]      req_word5 = '0;
   logic [WordWidth-1:0]      req_word6 = '0;
   logic [WordWidth-1:0]      req_word7 = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [BaseBitsWidth-1:0]  rsp_base_bits;
   logic [PlaneBitsWidth-1:0] rsp_plane_bits;
   logic [TotalBitsWidth-1:0] rsp_total_bits;

   line_type pending_lines [$];
   size_type expected_sizes [$];

   int total_lines    = 0;
   int lines_offered  = 0;
   int lines_accepted = 0;
   int sizes_checked  = 0;
   int stall_cycles   = 0;
   int error_count    = 0;
   int hold_left      = 0;
   bit hold_done      = 1'b0;

   bit_plane_compressed_size_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_word0      (req_word0),
      .req_word1      (req_word1),
      .req_word2      (req_word2),
      .req_word3      (req_word3),
      .req_word4      (req_word4),
      .req_word5      (req_word5),
      .req_word6      (req_word6),
      .req_word7      (req_word7),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_base_bits  (rsp_base_bits),
      .rsp_plane_bits (rsp_plane_bits),
      .rsp_total_bits (rsp_total_bits)
   );

   always #10 clock = ~clock;

   // Appends a line to the stimulus queue.
   task automatic queue_line(line_type ln);
      pending_lines.insert(pending_lines.size(), ln);
   endtask

   // Appends a predicted result to the scoreboard.
   task automatic expect_size(size_type sz);
      expected_sizes.insert(expected_sizes.size(), sz);
   endtask

   function automatic int unsigned zero_run_price(int unsigned run);
      if (run == 0) return 0;
      return (run == 1) ? CostRunOne : CostRunLong;
   endfunction

   // Code lengths of one line: base word, the 33 XORed delta planes, and their sum.
   function automatic size_type predict_size(line_type ln);
      logic signed [DeltaWidth-1:0] wide [LineWords];
      logic [DeltaWidth-1:0]        delta [DeltaCount];
      logic [DeltaCount-1:0]        plane [PlaneCount];
      logic [DeltaCount-1:0]        flip;
      logic signed [WordWidth-1:0]  base;
      int unsigned                  run;
      int unsigned                  bits;
      size_type                     sz;
      for (int i = 0; i < LineWords; i++) wide[i] = {ln[i][WordWidth-1], ln[i]};
      for (int r = 0; r < DeltaCount; r++) delta[r] = wide[r+1] - wide[r];
      for (int c = 0; c < PlaneCount; c++) begin
         for (int r = 0; r < DeltaCount; r++) plane[c][r] = delta[r][c];
      end
      base = ln[0];
      if (base == 0) sz.base_bits = BaseZero;
      else if (base >= -8 && base <= 7) sz.base_bits = BaseNibble;
      else if (base >= -128 && base <= 127) sz.base_bits = BaseByte;
      else if (base >= -32768 && base <= 32767) sz.base_bits = BaseHalf;
      else sz.base_bits = BaseFull;
      bits = 0;
      run = 0;
      // The top plane is coded as it stands; every lower one against the plane above.
      for (int c = PlaneCount - 1; c >= 0; c--) begin
         flip = (c == PlaneCount - 1) ? plane[c] : plane[c] ^ plane[c+1];
         if (flip == '0) begin
            run++;
         end else begin
            bits += zero_run_price(run);
            run = 0;
            bits += (plane[c] == '0 || flip == PlaneAllOnes) ? CostPlaneShort : CostPlaneLong;
         end
      end
      bits += zero_run_price(run);
      sz.plane_bits = bits[PlaneBitsWidth-1:0];
      sz.total_bits = TotalBitsWidth'(sz.base_bits + bits);
      return sz;
   endfunction

   // A random value that sign-extends from the given number of bits.
   function automatic word_type random_signed(int unsigned bits);
      logic signed [WordWidth-1:0] v;
      if (bits == 0) return '0;
      v = $urandom;
      v = v <<< (WordWidth - bits);
      v = v >>> (WordWidth - bits);
      return v;
   endfunction

   // Mostly lines with structured deltas, so that zero runs and sparse planes
   // turn up often; the rest are uniformly random words.
   function automatic line_type random_line();
      line_type    ln;
      int unsigned pick;
      int unsigned width;
      word_type    step;
      word_type    other;
      pick = $urandom_range(99);
      ln[0] = random_signed($urandom_range(WordWidth));
      width = $urandom_range(WordWidth);
      step = random_signed(width);
      other = $urandom;
      for (int i = 1; i < LineWords; i++) begin
         if (pick < 15) begin
            ln[i] = $urandom;
         end else if (pick < 25) begin
            ln[i] = ln[0];
         end else if (pick < 35) begin
            ln[i] = ln[i-1] + step;
         end else if (pick < 50) begin
            case ($urandom_range(3))
               0: ln[i] = ln[i-1];
               1: ln[i] = ln[i-1] + 1;
               2: ln[i] = ln[i-1] - 1;
               default: ln[i] = ln[i-1] + random_signed($urandom_range(6));
            endcase
         end else if (pick < 60) begin
            ln[i] = i[0] ? other : ln[0];
         end else begin
            ln[i] = ln[i-1] + random_signed(width);
         end
      end
      return ln;
   endfunction

   // Request driver: a new item goes out only once the previous one is taken.
   always @(negedge clock) begin : drive_lines
      line_type ln;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || lines_accepted == lines_offered) begin
         if (pending_lines.size() != 0 &&
             ((lines_offered >= 500 && lines_offered < 800) || $urandom_range(99) >= 8)) begin
            ln = pending_lines.pop_front();
            req_word0 <= ln[0];
            req_word1 <= ln[1];
            req_word2 <= ln[2];
            req_word3 <= ln[3];
            req_word4 <= ln[4];
            req_word5 <= ln[5];
            req_word6 <= ln[6];
            req_word7 <= ln[7];
            req_valid <= 1'b1;
            lines_offered <= lines_offered + 1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver, with one long hold-off to back the pipeline up.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && sizes_checked >= 300) begin
         rsp_ready <= 1'b0;
         hold_left <= 79;
         hold_done <= 1'b1;
      end else begin
         rsp_ready <= (sizes_checked >= 900 && sizes_checked < 1150) || ($urandom_range(99) >= 8);
      end
   end

   // Results are checked before the accepted line is predicted, so the order
   // of the two within one edge is fixed.
   always @(posedge clock) begin : check_sizes
      size_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_sizes.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("%0t: result with nothing expected: base %0d plane %0d total %0d",
                           $time, rsp_base_bits, rsp_plane_bits, rsp_total_bits);
            end else begin
               want = expected_sizes.pop_front();
               if (rsp_base_bits !== want.base_bits || rsp_plane_bits !== want.plane_bits ||
                   rsp_total_bits !== want.total_bits) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("%0t: result %0d expected base %0d plane %0d total %0d, got %0d %0d %0d",
                              $time, sizes_checked, want.base_bits, want.plane_bits,
                              want.total_bits, rsp_base_bits, rsp_plane_bits, rsp_total_bits);
               end
            end
            sizes_checked <= sizes_checked + 1;
         end
         if (req_valid && req_ready) begin
            expect_size(predict_size({req_word7, req_word6, req_word5, req_word4,
                                      req_word3, req_word2, req_word1, req_word0}));
            lines_accepted <= lines_accepted + 1;
         end
         if (req_valid && !req_ready) stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      word_type base_edges [17];
      line_type ln;
      // Boundaries of every base code length, each on a flat line.
      base_edges = '{32'h0000_0000, 32'h0000_0007, 32'hffff_fff8, 32'h0000_0008,
                     32'hffff_fff7, 32'h0000_007f, 32'hffff_ff80, 32'h0000_0080,
                     32'hffff_ff7f, 32'h0000_7fff, 32'hffff_8000, 32'h0000_8000,
                     32'hffff_7fff, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                     32'h0000_0001};
      foreach (base_edges[k]) queue_line({LineWords{base_edges[k]}});
      for (int i = 0; i < LineWords; i++) ln[i] = i;
      queue_line(ln);
      for (int i = 0; i < LineWords; i++) ln[i] = -i;
      queue_line(ln);
      // Widest deltas in both directions.
      for (int i = 0; i < LineWords; i++) ln[i] = i[0] ? 32'h8000_0000 : 32'h7fff_ffff;
      queue_line(ln);
      for (int i = 0; i < LineWords; i++) ln[i] = i[0] ? 32'h7fff_ffff : 32'h8000_0000;
      queue_line(ln);
      for (int i = 0; i < LineWords; i++) ln[i] = (i >= 4) ? 32'h0001_2345 : 32'h0;
      queue_line(ln);
      for (int i = 0; i < LineWords; i++) ln[i] = i * 32'h0101_0101;
      queue_line(ln);
      repeat (1300) queue_line(random_line());
      total_lines = pending_lines.size();

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (lines_accepted < total_lines || expected_sizes.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sized %0d lines and checked %0d results, with random gaps on both sides.",
               lines_accepted, sizes_checked);
      $display("The input was held off for %0d cycles; %0d errors were found.",
               stall_cycles, error_count);
      if (error_count == 0 && expected_sizes.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timeout after %0d of %0d lines and %0d results.",
               lines_accepted, total_lines, sizes_checked);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: files.f
rtl/core/bpcs_pkg.sv
rtl/core/bpcs_cost.sv
rtl/core/bit_plane_compressed_size_top.sv
dv/tb_bit_plane_compressed_size_top.sv
